// ===== rtl/etsd_pkg.sv =====
// Package with shared types and constants for the event time surface decay unit.
package etsd_pkg;

  // Surface geometry and value width, fixed for the whole design.
  localparam int MAX_WIDTH  = 128;
  localparam int MAX_HEIGHT = 128;
  localparam int VALUE_BITS = 16;

  typedef enum logic [1:0] {
    OP_BATCH = 2'd0,
    OP_EVENT = 2'd1,
    OP_READ  = 2'd2,
    OP_CLEAR = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    ST_DONE    = 2'd0,
    ST_OUT     = 2'd1,
    ST_NOFRAME = 2'd2
  } status_t;

  typedef enum logic [1:0] {
    CFG_WIDTH  = 2'd0,
    CFG_HEIGHT = 2'd1,
    CFG_RATE   = 2'd2,
    CFG_POLSEP = 2'd3
  } cfg_idx_t;

  typedef enum logic [3:0] {
    S_IDLE,
    S_CLRINIT,
    S_FMUL0,
    S_FMUL1,
    S_FSTEP,
    S_FDONE,
    S_SWEEP,
    S_EVREAD,
    S_RDWAIT,
    S_OUT
  } state_t;

  localparam logic [63:0] ONE_Q32   = 64'h1_0000_0000;
  localparam logic [63:0] LIMIT_Q24 = 64'd12 << 24;

  // exp(-2^(k-24)) in Q.32 for bit k of the Q.24 exponent, k = 0..27.
  function automatic logic [31:0] exp_entry(input logic [4:0] k);
    logic [31:0] r;
    unique case (k)
      5'd0:  r = 32'd4294967040;
      5'd1:  r = 32'd4294966784;
      5'd2:  r = 32'd4294966272;
      5'd3:  r = 32'd4294965248;
      5'd4:  r = 32'd4294963200;
      5'd5:  r = 32'd4294959104;
      5'd6:  r = 32'd4294950912;
      5'd7:  r = 32'd4294934528;
      5'd8:  r = 32'd4294901760;
      5'd9:  r = 32'd4294836226;
      5'd10: r = 32'd4294705160;
      5'd11: r = 32'd4294443040;
      5'd12: r = 32'd4293918848;
      5'd13: r = 32'd4292870656;
      5'd14: r = 32'd4290775039;
      5'd15: r = 32'd4286586875;
      5'd16: r = 32'd4278222805;
      5'd17: r = 32'd4261543595;
      5'd18: r = 32'd4228380000;
      5'd19: r = 32'd4162825044;
      5'd20: r = 32'd4034748381;
      5'd21: r = 32'd3790295335;
      5'd22: r = 32'd3344923893;
      5'd23: r = 32'd2605029347;
      5'd24: r = 32'd1580030169;
      5'd25: r = 32'd581260615;
      5'd26: r = 32'd78665070;
      5'd27: r = 32'd1440801;
      default: r = 32'd0;
    endcase
    return r;
  endfunction

endpackage

// ===== rtl/etsd_mul.sv =====
// Shared registered 32x32 multiplier used for the factor build and the pixel sweep.
module etsd_mul import etsd_pkg::*; (
  input  logic        clk,
  input  logic [31:0] a,
  input  logic [31:0] b,
  output logic [63:0] p
);

  logic [63:0] p_r;

  always_ff @(posedge clk) begin
    p_r <= {32'd0, a} * {32'd0, b};
  end

  assign p = p_r;

endmodule

// ===== rtl/event_time_surface_decay_unit.sv =====
// Top level of the event time surface decay unit.
// This block holds a positive and a negative time surface of MAX_WIDTH x
// MAX_HEIGHT values in two memories with one write and one read port each,
// and serves one item at a time; the input stays closed from the accepting
// beat until its result beat has been taken. An event writes its entry and
// then offers its result; a read goes through lookup, registered read and
// result; an item that is dropped or ignored offers its result directly. A
// batch start first builds the decay factor with one shared 32x32
// multiplier: the dt*rate product, then for each of the 28 exponent bits a
// multiply issued and collected when the bit is set, and a closing step. It
// then walks all MAX_WIDTH*MAX_HEIGHT entries through the same multiplier,
// each in the steps read, two products, write; a factor of zero skips the
// exponent bits, and a factor of one skips the walk. A clear item, and reset,
// sweep all entries to zero at one entry per cycle, so after reset the input
// accepts nothing until every entry has been cleared. Configuration writes
// are taken at any time but should only change between items. The result
// waits in an output register until taken.
module event_time_surface_decay_unit import etsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // [1:0] operation
  input  logic [1:0]  in_tuser,
  // [47:0] timestamp, [63:48] pixel_x, [79:64] pixel_y, [80] polarity,
  // [87:81] zero
  input  logic [87:0] in_tdata,
  output logic        out_tvalid,
  input  logic        out_tready,
  // [1:0] status
  output logic [1:0]  out_tuser,
  // [15:0] pos_value, [31:16] neg_value
  output logic [31:0] out_tdata,
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  localparam int CELLS = MAX_WIDTH * MAX_HEIGHT;
  localparam int AW    = $clog2(CELLS);
  localparam logic [VALUE_BITS-1:0] FULL = {VALUE_BITS{1'b1}};

  logic [VALUE_BITS-1:0] pos_mem [CELLS];
  logic [VALUE_BITS-1:0] neg_mem [CELLS];

  logic [7:0]  fw_r, fh_r;
  logic [31:0] rate_r;
  logic        polsep_r;

  state_t state_r, state_nxt;
  logic [47:0] prev_r, prev_nxt;
  logic        havep_r, havep_nxt;
  logic [1:0]  op_r, op_nxt;
  logic        pol_r, pol_nxt;
  logic [AW-1:0] idx_r, idx_nxt;
  logic [AW:0]   cnt_r, cnt_nxt;
  logic [31:0] dt_r, dt_nxt;
  logic [63:0] e_r, e_nxt;
  logic [63:0] f_r, f_nxt;
  logic [4:0]  k_r, k_nxt;
  logic        ov_r, ov_nxt;
  logic [1:0]  ost_r, ost_nxt;
  logic [15:0] opos_r, opos_nxt, oneg_r, oneg_nxt;
  logic        ovld_r, ovld_nxt;
  logic        ph_r, ph_nxt;

  logic [VALUE_BITS-1:0] rpos_r, rneg_r;
  logic        we;
  logic [AW-1:0] waddr, raddr;
  logic [VALUE_BITS-1:0] wpos, wneg;
  logic        wp_en, wn_en;

  logic [31:0] ma, mb;
  logic [63:0] mp;

  etsd_mul u_mul (.clk(clk), .a(ma), .b(mb), .p(mp));

  // Input field unpack.
  logic [1:0]  in_op;
  logic [47:0] in_ts;
  logic [15:0] in_x, in_y;
  logic        in_pol;
  assign in_op  = in_tuser;
  assign in_ts  = in_tdata[47:0];
  assign in_x   = in_tdata[63:48];
  assign in_y   = in_tdata[79:64];
  assign in_pol = in_tdata[80];

  logic [8:0] w_eff, h_eff;
  assign w_eff = (fw_r > 8'(MAX_WIDTH))  ? 9'(MAX_WIDTH)  : {1'b0, fw_r};
  assign h_eff = (fh_r > 8'(MAX_HEIGHT)) ? 9'(MAX_HEIGHT) : {1'b0, fh_r};

  logic [25:0] lin;
  assign lin = 26'(in_y[8:0]) * 26'(w_eff) + 26'(in_x[8:0]);

  assign cfg_ready = 1'b1;
  assign in_tready = (state_r == S_IDLE) && !ovld_r;
  assign out_tvalid = ovld_r;
  assign out_tuser  = ost_r;
  assign out_tdata  = {oneg_r, opos_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      fw_r <= '0; fh_r <= '0; rate_r <= '0; polsep_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_idx_t'(cfg_index))
        CFG_WIDTH:  fw_r     <= cfg_data[7:0];
        CFG_HEIGHT: fh_r     <= cfg_data[7:0];
        CFG_RATE:   rate_r   <= cfg_data;
        CFG_POLSEP: polsep_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (wp_en) pos_mem[waddr] <= wpos;
    if (wn_en) neg_mem[waddr] <= wneg;
    rpos_r <= pos_mem[raddr];
    rneg_r <= neg_mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_CLRINIT;
      prev_r  <= '0;
      havep_r <= 1'b0;
      ovld_r  <= 1'b0;
      cnt_r   <= '0;
      ph_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      prev_r  <= prev_nxt;
      havep_r <= havep_nxt;
      ovld_r  <= ovld_nxt;
      cnt_r   <= cnt_nxt;
      ph_r    <= ph_nxt;
    end
    op_r <= op_nxt; pol_r <= pol_nxt; idx_r <= idx_nxt; dt_r <= dt_nxt;
    e_r <= e_nxt; f_r <= f_nxt; k_r <= k_nxt; ov_r <= ov_nxt;
    ost_r <= ost_nxt; opos_r <= opos_nxt; oneg_r <= oneg_nxt;
  end

  logic [63:0] vprod;
  assign vprod = mp + 64'h8000_0000;

  always_comb begin
    state_nxt = state_r; prev_nxt = prev_r; havep_nxt = havep_r;
    op_nxt = op_r; pol_nxt = pol_r; idx_nxt = idx_r; cnt_nxt = cnt_r;
    dt_nxt = dt_r; e_nxt = e_r; f_nxt = f_r; k_nxt = k_r; ov_nxt = ov_r;
    ost_nxt = ost_r; opos_nxt = opos_r; oneg_nxt = oneg_r; ph_nxt = ph_r;
    ovld_nxt = ovld_r;
    wp_en = 1'b0; wn_en = 1'b0; waddr = idx_r; raddr = idx_r;
    wpos = '0; wneg = '0; we = 1'b0;
    ma = '0; mb = '0;
    if (ovld_r && out_tready) ovld_nxt = 1'b0;
    unique case (state_r)
      S_CLRINIT: begin
        wp_en = 1'b1; wn_en = 1'b1; waddr = cnt_r[AW-1:0];
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == (AW+1)'(CELLS - 1)) begin
          cnt_nxt = '0;
          if (op_r == OP_CLEAR && ph_r) begin
            ph_nxt = 1'b0; ost_nxt = ST_DONE; opos_nxt = '0; oneg_nxt = '0;
            state_nxt = S_OUT;
          end else begin
            state_nxt = S_IDLE;
          end
        end
      end
      S_IDLE: begin
        if (in_tvalid && in_tready) begin
          op_nxt = in_op; pol_nxt = in_pol; idx_nxt = lin[AW-1:0];
          ost_nxt = ST_DONE; opos_nxt = '0; oneg_nxt = '0;
          if (w_eff == 9'd0 || h_eff == 9'd0) begin
            ost_nxt = ST_NOFRAME; state_nxt = S_OUT;
          end else begin
            unique case (op_t'(in_op))
              OP_BATCH: begin
                dt_nxt = '0; ov_nxt = 1'b0;
                if (havep_r && in_ts > prev_r) begin
                  dt_nxt = 32'(in_ts - prev_r);
                  ov_nxt = ((in_ts - prev_r) >> 32) != 48'd0;
                end
                prev_nxt = in_ts; havep_nxt = 1'b1;
                state_nxt = S_FMUL0;
              end
              OP_CLEAR: begin
                prev_nxt = '0; havep_nxt = 1'b0; ph_nxt = 1'b1;
                cnt_nxt = '0; state_nxt = S_CLRINIT;
              end
              default: begin
                if (in_x[15] || in_y[15] || in_x >= {7'd0, w_eff} ||
                    in_y >= {7'd0, h_eff} || lin >= 26'(CELLS)) begin
                  ost_nxt = ST_OUT; state_nxt = S_OUT;
                end else begin
                  state_nxt = S_EVREAD;
                end
              end
            endcase
          end
        end
      end
      S_FMUL0: begin
        ma = dt_r; mb = rate_r; state_nxt = S_FMUL1;
      end
      S_FMUL1: begin
        e_nxt = mp; f_nxt = ONE_Q32; k_nxt = '0; ph_nxt = 1'b0;
        // An elapsed time of 2^32 or more can have zero low bits but still decays to zero unless the rate is zero.
        if ((dt_r == 32'd0 && !ov_r) || rate_r == 32'd0) state_nxt = S_OUT;
        else if (ov_r || mp >= LIMIT_Q24) begin
          f_nxt = '0; cnt_nxt = '0; state_nxt = S_SWEEP;
        end else state_nxt = S_FSTEP;
      end
      S_FSTEP: begin
        // ph=0 issues a multiply for bit k when set; ph=1 collects it.
        if (!ph_r) begin
          if (e_r[k_r]) begin
            ma = (f_r[32]) ? 32'hFFFF_FFFF : f_r[31:0];
            mb = exp_entry(k_r);
            ph_nxt = 1'b1;
          end else if (k_r == 5'd27) state_nxt = S_FDONE;
          else k_nxt = k_r + 1'b1;
        end else begin
          // Multiplying 2^32 by an entry gives the entry itself.
          f_nxt = f_r[32] ? {32'd0, exp_entry(k_r)} : (mp >> 32);
          ph_nxt = 1'b0;
          if (k_r == 5'd27) state_nxt = S_FDONE;
          else k_nxt = k_r + 1'b1;
        end
      end
      S_FDONE: begin
        cnt_nxt = '0; ph_nxt = 1'b0;
        state_nxt = (f_r >= ONE_Q32) ? S_OUT : S_SWEEP;
      end
      S_SWEEP: begin
        // Each entry takes the steps read both, scale pos, scale neg, write both.
        raddr = cnt_r[AW-1:0]; waddr = cnt_r[AW-1:0];
        if (!ph_r) begin
          ph_nxt = 1'b1;
          k_nxt = '0;
        end else begin
          unique case (k_r)
            5'd0: begin
              ma = 32'(rpos_r); mb = f_r[31:0]; k_nxt = 5'd1;
            end
            5'd1: begin
              ma = 32'(rneg_r); mb = f_r[31:0]; k_nxt = 5'd2;
              dt_nxt = vprod[63:32];
            end
            default: begin
              wp_en = 1'b1; wn_en = 1'b1;
              wpos = dt_r[VALUE_BITS-1:0]; wneg = vprod[32 +: VALUE_BITS];
              ph_nxt = 1'b0;
              cnt_nxt = cnt_r + 1'b1;
              if (cnt_r == (AW+1)'(CELLS - 1)) begin
                cnt_nxt = '0; state_nxt = S_OUT;
              end
            end
          endcase
        end
      end
      S_EVREAD: begin
        if (op_r == OP_EVENT) begin
          wpos = FULL; wneg = FULL;
          if (polsep_r && !pol_r) wn_en = 1'b1;
          else wp_en = 1'b1;
          state_nxt = S_OUT;
        end else state_nxt = S_RDWAIT;
      end
      S_RDWAIT: begin
        opos_nxt = 16'(rpos_r);
        oneg_nxt = polsep_r ? 16'(rneg_r) : 16'(rpos_r);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        ovld_nxt = 1'b1; state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
    we = wp_en | wn_en;
    if (we && state_r == S_CLRINIT) begin
      wpos = '0; wneg = '0;
    end
  end

endmodule

// ===== verif/event_time_surface_decay_checker.sv =====
`timescale 1ns / 100ps
// Checker for the event time surface decay unit: watches all channels, predicts and compares.
module event_time_surface_decay_checker import etsd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  input  logic        in_tready,
  input  logic [1:0]  in_tuser,
  input  logic [87:0] in_tdata,
  input  logic        out_tvalid,
  input  logic        out_tready,
  input  logic [1:0]  out_tuser,
  input  logic [31:0] out_tdata,
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          fail_count,
  output int          results_owed
);

  localparam int CELLS = 128 * 128;

  typedef struct packed {
    status_t     status;
    logic [15:0] pos_value;
    logic [15:0] neg_value;
  } surface_result_t;

  // exp(-2^(k-24)) in Q.32, k being the bit of the Q.24 exponent.
  localparam logic [31:0] EXP_Q32 [28] = '{
    32'd4294967040, 32'd4294966784, 32'd4294966272, 32'd4294965248,
    32'd4294963200, 32'd4294959104, 32'd4294950912, 32'd4294934528,
    32'd4294901760, 32'd4294836226, 32'd4294705160, 32'd4294443040,
    32'd4293918848, 32'd4292870656, 32'd4290775039, 32'd4286586875,
    32'd4278222805, 32'd4261543595, 32'd4228380000, 32'd4162825044,
    32'd4034748381, 32'd3790295335, 32'd3344923893, 32'd2605029347,
    32'd1580030169, 32'd581260615,  32'd78665070,   32'd1440801
  };

  logic [15:0] pos_surface [CELLS];
  logic [15:0] neg_surface [CELLS];
  logic [47:0] last_batch_ts;
  logic        have_last_ts;
  logic [7:0]  width_reg, height_reg;
  logic [31:0] rate_reg;
  logic        sep_reg;
  surface_result_t owed_q[$];

  // Q.32 decay factor for an elapsed time; 2^32 means no change.
  function automatic logic [63:0] decay_factor_q32(input logic [47:0] dt);
    logic [63:0] e, f;
    if (dt == 0 || rate_reg == 0) return 64'h1_0000_0000;
    if (dt >= 48'h1_0000_0000) return 64'd0;
    e = dt * rate_reg;
    if (e >= (64'd12 << 24)) return 64'd0;
    f = 64'h1_0000_0000;
    for (int k = 0; k < 28; k++)
      if (e[k]) f = (f * EXP_Q32[k]) >> 32;
    return f;
  endfunction

  function automatic surface_result_t predict_surface(input logic [1:0] kind,
                                                      input logic [87:0] beat);
    op_t             op;
    logic [47:0]     ts, dt;
    logic [15:0]     x, y;
    logic [63:0]     f;
    int unsigned     w, h, idx;
    surface_result_t r;
    op = op_t'(kind);
    ts = beat[47:0];
    x  = beat[63:48];
    y  = beat[79:64];
    r  = '{status: ST_DONE, pos_value: 16'd0, neg_value: 16'd0};
    w  = (width_reg > 128) ? 128 : width_reg;
    h  = (height_reg > 128) ? 128 : height_reg;
    if (w == 0 || h == 0) begin
      r.status = ST_NOFRAME;
      return r;
    end
    case (op)
      OP_BATCH: begin
        dt = (have_last_ts && ts > last_batch_ts) ? ts - last_batch_ts : 48'd0;
        last_batch_ts = ts;
        have_last_ts  = 1'b1;
        f = decay_factor_q32(dt);
        if (f < 64'h1_0000_0000) begin
          for (int i = 0; i < CELLS; i++) begin
            pos_surface[i] = 16'((64'(pos_surface[i]) * f + 64'h8000_0000) >> 32);
            neg_surface[i] = 16'((64'(neg_surface[i]) * f + 64'h8000_0000) >> 32);
          end
        end
      end
      OP_CLEAR: begin
        for (int i = 0; i < CELLS; i++) begin
          pos_surface[i] = 16'd0;
          neg_surface[i] = 16'd0;
        end
        last_batch_ts = 48'd0;
        have_last_ts  = 1'b0;
      end
      default: begin
        // Negative coordinates have the top bit set and so never fit.
        if (x >= w || y >= h) begin
          r.status = ST_OUT;
        end else begin
          idx = y * w + x;
          if (op == OP_EVENT) begin
            if (sep_reg && !beat[80]) neg_surface[idx] = 16'hFFFF;
            else pos_surface[idx] = 16'hFFFF;
          end else begin
            r.pos_value = pos_surface[idx];
            r.neg_value = sep_reg ? neg_surface[idx] : pos_surface[idx];
          end
        end
      end
    endcase
    return r;
  endfunction

  assign results_owed = owed_q.size();

  always @(posedge clk) begin
    surface_result_t want, got;
    if (!rst_n) begin
      for (int i = 0; i < CELLS; i++) begin
        pos_surface[i] = 16'd0;
        neg_surface[i] = 16'd0;
      end
      last_batch_ts = 48'd0;
      have_last_ts  = 1'b0;
      width_reg  = 8'd0;
      height_reg = 8'd0;
      rate_reg   = 32'd0;
      sep_reg    = 1'b0;
      fail_count = 0;
      owed_q.delete();
    end else begin
      // A result beat always belongs to an earlier input beat, so check it first.
      if (out_tvalid && out_tready) begin
        got = '{status: status_t'(out_tuser), pos_value: out_tdata[15:0],
                neg_value: out_tdata[31:16]};
        if (owed_q.size() == 0) begin
          $display("%0t: result beat with nothing owed, expected none, actual %h",
                   $time, got);
          fail_count++;
        end else begin
          want = owed_q.pop_front();
          if (got.status !== want.status) begin
            $display("%0t: status expected %0d actual %0d", $time, want.status, got.status);
            fail_count++;
          end
          if (got.pos_value !== want.pos_value) begin
            $display("%0t: pos_value expected %0d actual %0d", $time, want.pos_value,
                     got.pos_value);
            fail_count++;
          end
          if (got.neg_value !== want.neg_value) begin
            $display("%0t: neg_value expected %0d actual %0d", $time, want.neg_value,
                     got.neg_value);
            fail_count++;
          end
        end
      end
      if (in_tvalid && in_tready) owed_q.push_back(predict_surface(in_tuser, in_tdata));
      if (cfg_valid && cfg_ready) begin
        case (cfg_idx_t'(cfg_index))
          CFG_WIDTH:  width_reg  = cfg_data[7:0];
          CFG_HEIGHT: height_reg = cfg_data[7:0];
          CFG_RATE:   rate_reg   = cfg_data;
          CFG_POLSEP: sep_reg    = cfg_data[0];
        endcase
      end
    end
  end

endmodule

// ===== verif/event_time_surface_decay_unit_test.sv =====
`timescale 1ns / 100ps
// Top of the event time surface decay unit testbench: stimulus, clocking and verdict.
module event_time_surface_decay_unit_test import etsd_pkg::*;;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [1:0]  in_tuser = '0;
  logic [87:0] in_tdata = '0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [1:0]  out_tuser;
  logic [31:0] out_tdata;
  logic        cfg_valid = 1'b0;
  logic        cfg_ready;
  logic [1:0]  cfg_index = '0;
  logic [31:0] cfg_data = '0;
  int          fail_count;
  int          results_owed;

  // Stimulus-side knobs: calm turns off random idling on both sides, and
  // sink_hold makes the receiver refuse results for a long stretch.
  bit          calm = 1'b0;
  bit          hold_go = 1'b0;
  logic        sink_hold = 1'b0;

  // Current frame and time base, so random beats land mostly inside the frame.
  int unsigned cur_w, cur_h;
  logic [47:0] now_us = 48'd0;

  always #5 clk = ~clk;

  event_time_surface_decay_unit dut (.*);

  event_time_surface_decay_checker checker_i (.*);

  // Receiver: accepts at random unless calm or held off.
  always @(posedge clk) begin
    if (!rst_n) out_tready <= 1'b0;
    else if (sink_hold) out_tready <= 1'b0;
    else if (calm) out_tready <= 1'b1;
    else out_tready <= ($urandom_range(99) >= 23);
  end

  // Long hold-off on the result side, counted in its own process. The sender
  // keeps offering beats meanwhile, so the output register fills and the
  // input must stall.
  initial begin
    wait (hold_go);
    @(posedge clk);
    sink_hold <= 1'b1;
    repeat (600) @(posedge clk);
    sink_hold <= 1'b0;
  end

  initial begin
    #200_000_000;
    $display("TB_ERROR");
    $finish;
  end

  // Offers one input beat and returns just after the edge that accepted it.
  // Ready only changes at rising edges, so it is sampled at the falling edge.
  task automatic send_beat(input op_t op, input logic [47:0] ts, input logic [15:0] x,
                           input logic [15:0] y, input logic pol);
    logic rdy;
    if (!calm && $urandom_range(99) < 23) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {7'd0, pol, y, x, ts};
    do begin
      @(negedge clk);
      rdy = in_tready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // Holds one register write until accepted; the caller lowers valid.
  task automatic write_reg(input cfg_idx_t idx, input logic [31:0] value);
    logic rdy;
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do begin
      @(negedge clk);
      rdy = cfg_ready;
      @(posedge clk);
    end while (!rdy);
  endtask

  // Waits until every result is in and the block has had time to settle,
  // then programs a new setting.
  task automatic reconfigure(input logic [7:0] w, input logic [7:0] h,
                             input logic [31:0] rate, input logic sep);
    in_tvalid <= 1'b0;
    @(negedge clk);
    wait (results_owed == 0);
    repeat (10) @(posedge clk);
    write_reg(CFG_WIDTH, 32'(w));
    write_reg(CFG_HEIGHT, 32'(h));
    write_reg(CFG_RATE, rate);
    write_reg(CFG_POLSEP, 32'(sep));
    cfg_valid <= 1'b0;
    cur_w = (w > 128) ? 128 : w;
    cur_h = (h > 128) ? 128 : h;
  endtask

  // One random beat. Batches and clears are rare since each walks the
  // whole surface; events and reads mostly hit the frame or its border.
  task automatic random_beat();
    int unsigned pick;
    logic [15:0] x, y;
    pick = $urandom_range(999);
    if ($urandom_range(9) == 0) x = 16'($urandom);
    else x = 16'($urandom_range(cur_w + 1));
    if ($urandom_range(9) == 0) y = 16'($urandom);
    else y = 16'($urandom_range(cur_h + 1));
    if (pick < 5) begin
      if ($urandom_range(4) == 0) now_us = 48'({$urandom, $urandom});
      else now_us = now_us + 48'($urandom_range(3000));
      send_beat(OP_BATCH, now_us, 16'($urandom), 16'($urandom), 1'($urandom));
    end else if (pick < 8) begin
      send_beat(OP_CLEAR, 48'({$urandom, $urandom}), x, y, 1'($urandom));
    end else if (pick < 500) begin
      send_beat(OP_EVENT, 48'({$urandom, $urandom}), x, y, 1'($urandom));
    end else begin
      send_beat(OP_READ, 48'({$urandom, $urandom}), x, y, 1'($urandom));
    end
  endtask

  initial begin
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    // No frame yet: everything is ignored, clear included.
    send_beat(OP_BATCH, 48'd77, 16'd0, 16'd0, 1'b1);
    send_beat(OP_EVENT, 48'd0, 16'd0, 16'd0, 1'b1);
    send_beat(OP_CLEAR, 48'd0, 16'd0, 16'd0, 1'b0);

    // Full frame, width beyond the maximum clamps, separate polarities,
    // tau of about 1000 us.
    reconfigure(8'd255, 8'd128, 32'd16777, 1'b1);
    send_beat(OP_EVENT, 48'd0, 16'd0, 16'd0, 1'b1);
    send_beat(OP_EVENT, 48'd0, 16'd127, 16'd127, 1'b0);
    send_beat(OP_EVENT, 48'd0, 16'hFFFF, 16'd0, 1'b1);
    send_beat(OP_EVENT, 48'd0, 16'd0, 16'd128, 1'b1);
    send_beat(OP_EVENT, 48'd0, 16'h7FFF, 16'h8000, 1'b0);
    send_beat(OP_READ, 48'd0, 16'd0, 16'd0, 1'b0);
    send_beat(OP_READ, 48'd0, 16'd127, 16'd127, 1'b0);
    send_beat(OP_READ, 48'd0, 16'h8000, 16'd5, 1'b0);
    // The first batch has no previous time and so does not decay.
    send_beat(OP_BATCH, 48'd1000, 16'd0, 16'd0, 1'b0);
    send_beat(OP_READ, 48'd0, 16'd0, 16'd0, 1'b0);
    send_beat(OP_BATCH, 48'd1700, 16'd0, 16'd0, 1'b0);
    send_beat(OP_READ, 48'd0, 16'd0, 16'd0, 1'b0);
    send_beat(OP_READ, 48'd0, 16'd127, 16'd127, 1'b0);
    // Time going backwards gives no decay; a huge step decays to zero.
    send_beat(OP_BATCH, 48'd500, 16'd0, 16'd0, 1'b0);
    send_beat(OP_BATCH, 48'hFFFF_FFFF_FFFF, 16'd0, 16'd0, 1'b0);
    send_beat(OP_READ, 48'd0, 16'd127, 16'd127, 1'b0);
    send_beat(OP_CLEAR, 48'd0, 16'd0, 16'd0, 1'b0);
    send_beat(OP_READ, 48'd0, 16'd3, 16'd3, 1'b0);

    // Polarity not separated: negative events land on the positive surface,
    // and a frame size change keeps stored values.
    reconfigure(8'd5, 8'd3, 32'hFFFF_FFFF, 1'b0);
    send_beat(OP_EVENT, 48'd0, 16'd4, 16'd2, 1'b0);
    send_beat(OP_READ, 48'd0, 16'd4, 16'd2, 1'b1);
    send_beat(OP_READ, 48'd0, 16'd5, 16'd2, 1'b1);

    // Random phases through several settings, extremes among them.
    reconfigure(8'd128, 8'd128, 32'd16777, 1'b1);
    hold_go = 1'b1;
    repeat (400) random_beat();
    reconfigure(8'd1, 8'd1, 32'd0, 1'b1);
    repeat (300) random_beat();
    reconfigure(8'd17, 8'd9, $urandom_range(200000), 1'b1);
    calm = 1'b1;
    repeat (300) random_beat();
    calm = 1'b0;
    reconfigure(8'd255, 8'd255, 32'hFFFF_FFFF, 1'($urandom_range(1)));
    repeat (300) random_beat();
    reconfigure(8'd0, 8'd40, 32'd16777, 1'b1);
    repeat (100) random_beat();
    reconfigure(8'd130, 8'd0, 32'd16777, 1'b0);
    repeat (100) random_beat();
    reconfigure(8'($urandom_range(1, 200)), 8'($urandom_range(1, 200)),
                $urandom_range(50000), 1'($urandom_range(1)));
    repeat (500) random_beat();

    in_tvalid <= 1'b0;
    @(negedge clk);
    wait (results_owed == 0);
    repeat (100) @(posedge clk);
    if (fail_count == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule

// ===== files.f =====
rtl/etsd_pkg.sv
rtl/etsd_mul.sv
rtl/event_time_surface_decay_unit.sv
verif/event_time_surface_decay_checker.sv
verif/event_time_surface_decay_unit_test.sv
